// ===== src/qsnv_pkg.sv =====
// ----------------------------------------------------------------------------
// qsnv_pkg
// shared types and character constants for the qualified name validator
// ----------------------------------------------------------------------------
`default_nettype none

package qsnv_pkg;

  // parse phase codes
  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_UNQ    = 3'd1,
    PH_QUOTED = 3'd2,
    PH_QSEEN  = 3'd3,
    PH_AFTER  = 3'd4,
    PH_BAD    = 3'd5
  } phase_t;

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_DOLLAR     = 8'h24;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0D;

  // character classes of one byte
  typedef struct packed {
    logic ws;
    logic first;
    logic more;
    logic dot;
    logic quote;
  } char_class_t;

endpackage

`default_nettype wire

// ===== src/qsnv_char_class.sv =====
// ----------------------------------------------------------------------------
// qsnv_char_class
// sorts one byte into the classes used by the name parser
// ----------------------------------------------------------------------------
`default_nettype none

module qsnv_char_class (
  input  wire logic [7:0]           char_byte,
  output qsnv_pkg::char_class_t     cls
);

  logic is_first;

  always_comb begin
    is_first = (char_byte == qsnv_pkg::CH_UNDERSCORE) ||
               (char_byte inside {[8'h61:8'h7A]}) ||
               (char_byte inside {[8'h41:8'h5A]}) ||
               char_byte[7];
    cls.ws    = (char_byte == qsnv_pkg::CH_SPACE) ||
                (char_byte inside {[qsnv_pkg::CH_TAB:qsnv_pkg::CH_CR]});
    cls.first = is_first;
    cls.more  = is_first || (char_byte == qsnv_pkg::CH_DOLLAR) ||
                (char_byte inside {[8'h30:8'h39]});
    cls.dot   = (char_byte == qsnv_pkg::CH_DOT);
    cls.quote = (char_byte == qsnv_pkg::CH_QUOTE);
  end

endmodule

`default_nettype wire

// ===== src/qsnv_phase_fsm.sv =====
// ----------------------------------------------------------------------------
// qsnv_phase_fsm
// parse phase register and its transition logic
// ----------------------------------------------------------------------------
`default_nettype none

module qsnv_phase_fsm (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire logic                 last,
  input  wire qsnv_pkg::char_class_t cls,
  output logic                      name_ok
);

  qsnv_pkg::phase_t phase;
  qsnv_pkg::phase_t phase_next;
  qsnv_pkg::phase_t ph_after;
  qsnv_pkg::phase_t ph_new;

  // next state
  always_comb begin
    if (cls.ws) begin
      ph_after = qsnv_pkg::PH_AFTER;
    end else if (cls.dot) begin
      ph_after = qsnv_pkg::PH_START;
    end else begin
      ph_after = qsnv_pkg::PH_BAD;
    end

    case (phase)
      qsnv_pkg::PH_START: begin
        if (cls.ws) begin
          ph_new = qsnv_pkg::PH_START;
        end else if (cls.quote) begin
          ph_new = qsnv_pkg::PH_QUOTED;
        end else if (cls.first) begin
          ph_new = qsnv_pkg::PH_UNQ;
        end else begin
          ph_new = qsnv_pkg::PH_BAD;
        end
      end
      qsnv_pkg::PH_UNQ: begin
        ph_new = cls.more ? qsnv_pkg::PH_UNQ : ph_after;
      end
      qsnv_pkg::PH_QUOTED: begin
        ph_new = cls.quote ? qsnv_pkg::PH_QSEEN : qsnv_pkg::PH_QUOTED;
      end
      qsnv_pkg::PH_QSEEN: begin
        ph_new = cls.quote ? qsnv_pkg::PH_QUOTED : ph_after;
      end
      qsnv_pkg::PH_AFTER: begin
        ph_new = ph_after;
      end
      default: begin
        ph_new = qsnv_pkg::PH_BAD;
      end
    endcase

    if (!step) begin
      phase_next = phase;
    end else if (last) begin
      phase_next = qsnv_pkg::PH_START;
    end else begin
      phase_next = ph_new;
    end
  end

  // outputs
  always_comb begin
    name_ok = ph_new inside {qsnv_pkg::PH_UNQ, qsnv_pkg::PH_QSEEN, qsnv_pkg::PH_AFTER};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= qsnv_pkg::PH_START;
    end else begin
      phase <= phase_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/qualified_sql_name_validator.sv =====
// ----------------------------------------------------------------------------
// qualified_sql_name_validator
// byte-stream checker for dot-separated qualified sql names
// ----------------------------------------------------------------------------
// Feed the name one byte per request on the slave side, with s_tlast set on
// the final byte. Parts are unquoted identifiers (letter, underscore or high
// bit byte first, then also digits or dollar) or double-quoted strings where
// two quotes in a row stand for one; whitespace may surround parts and dots.
// Exactly one result leaves on the master side for every byte that carries
// s_tlast: bit 0 of m_tdata is 1 when the whole string was a valid name.
// Bytes without s_tlast give no result. The block takes one byte per cycle
// while results are being taken; a byte passes through the input register
// and the verdict is held in the result register before m_tvalid rises. The
// rate is set by the phase update in the parser; a stalled result register
// only holds off the next last byte, ordinary bytes keep flowing behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module qualified_sql_name_validator (
  input  wire logic       clk,
  input  wire logic       rst,
  // request side
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] char_byte
  input  wire logic       s_tlast,   // is_last
  // result side
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata    // [0] name_ok, [7:1] zero
);

  // input register
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_last;

  // result register
  logic       out_ok;

  logic                  out_free;
  logic                  fire;
  logic                  ok_comb;
  qsnv_pkg::char_class_t cls;

  // the result register frees when empty or being taken this cycle
  assign out_free = !m_tvalid || m_tready;
  // an ordinary byte always moves on, a last byte needs a free result slot
  assign fire     = in_valid && (!in_last || out_free);
  assign s_tready = !in_valid || fire;

  qsnv_char_class u_class (
    .char_byte (in_char),
    .cls       (cls)
  );

  qsnv_phase_fsm u_fsm (
    .clk     (clk),
    .rst     (rst),
    .step    (fire),
    .last    (in_last),
    .cls     (cls),
    .name_ok (ok_comb)
  );

  // input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // input payload, no reset needed
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= fire && in_last;
    end
  end

  // verdict payload
  always_ff @(posedge clk) begin
    if (fire && in_last) begin
      out_ok <= ok_comb;
    end
  end

  assign m_tdata = {7'b0, out_ok};

endmodule

`default_nettype wire

// ===== src/qsnv_checker.sv =====
// ----------------------------------------------------------------------------
// qsnv_checker
// port-level checks for the qualified name validator
// ----------------------------------------------------------------------------
`default_nettype none

module qsnv_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tvalid,
  input wire logic       s_tready,
  input wire logic [7:0] s_tdata,
  input wire logic       s_tlast,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata
);

  // a pending result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped or changed while stalled");

  // only the verdict bit is ever set
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:1] == 7'd0)
    else $error("padding bits of result not zero");

  // reset empties the result register
  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // with room on the result side the input never stalls
  a_flow: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled while result side free");

  // a waiting request keeps its byte and last flag
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast))
    else $error("request changed while stalled");

endmodule

bind qualified_sql_name_validator qsnv_checker u_qsnv_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
